FILE: design/assert_macros.svh
// Assertion macros shared by the divider and the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks an implication at every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/mwsp_pkg.sv
package mwsp_pkg;

    localparam int DIVN_W = 48;
    localparam int DIVD_W = 20;
    localparam int MULA_W = 33;
    localparam int MULB_W = 18;
    localparam int PROD_W = MULA_W + MULB_W;
    localparam int HEAD_W = 17;
    localparam int CFG_W  = 40;

    localparam logic [2:0] CFG_GAINS_FL = 3'd0;
    localparam logic [2:0] CFG_GAINS_FR = 3'd1;
    localparam logic [2:0] CFG_GAINS_RL = 3'd2;
    localparam logic [2:0] CFG_GAINS_RR = 3'd3;
    localparam logic [2:0] CFG_GEOMETRY = 3'd4;
    localparam logic [2:0] CFG_SCALE    = 3'd5;
    localparam logic [2:0] CFG_STEP     = 3'd6;
    localparam logic [2:0] CFG_SIGNS    = 3'd7;

    localparam logic [15:0] GEOMETRY_RESET = 16'd840;
    localparam logic [15:0] SCALE_RESET    = 16'd34944;
    localparam logic [15:0] STEP_RESET     = 16'd2621;
    localparam logic [3:0]  SIGNS_RESET    = 4'd5;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Shift right with rounding to nearest, ties away from zero.
    function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                     input int s);
        logic [63:0] m;
        logic [63:0] r;
        m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
        r = (m + (64'd1 << (s - 1))) >> s;
        return v[63] ? signed'(64'd0 - r) : signed'(r);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767)
            return 16'sh7fff;
        else if (v < -64'sd32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

endpackage

FILE: design/mwsp_div.sv
`include "assert_macros.svh"
module mwsp_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mwsp_pkg::DIVN_W-1:0]  dividend,
    input  logic [mwsp_pkg::DIVD_W-1:0]  divisor,
    output mwsp_pkg::div_stat_t          stat,
    output logic [mwsp_pkg::DIVN_W-1:0]  quotient
);
    import mwsp_pkg::*;

    localparam int CNT_W = $clog2(DIVN_W + 1);

    logic [DIVD_W:0]   rem_reg, rem_next;
    logic [DIVN_W-1:0] quo_reg, quo_next;
    logic [DIVD_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVD_W:0]   trial;

    always_comb
    begin
        trial     = {rem_reg[DIVD_W-1:0], quo_reg[DIVN_W-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(DIVN_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[DIVN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DIVN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
            dvs_reg <= divisor;
    end

    assign stat     = {busy_reg, done_reg};
    assign quotient = quo_reg;

    `ASSERT_IMPL(a_div_done_idle, done_reg, !busy_reg, "divider done while busy")
endmodule

FILE: design/mwsp_mul.sv
module mwsp_mul (
    input  logic                                clk,
    input  logic signed [mwsp_pkg::MULA_W-1:0]  a,
    input  logic signed [mwsp_pkg::MULB_W-1:0]  b,
    output logic signed [mwsp_pkg::PROD_W-1:0]  prod
);
    import mwsp_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;
endmodule

FILE: design/mecanum_wheel_speed_pi.sv
// A tick runs kinematics, then the four wheel speeds, then a PI step per wheel, and then
// hands the result off. The shared 48-step divider runs once per wheel for the speed and
// once per wheel with a nonzero target for the integral limit; a wheel with a zero target
// skips the divider and the rest of its PI steps, and its integral and drive are cleared.
// Input is not ready while a tick is in work.
// The result sits in an output register, so the next input is taken while it waits.
// Reset clears the integrals and the configuration to its defaults at once.
`include "assert_macros.svh"
module mecanum_wheel_speed_pi #(
    parameter int PWM_MAX = 255
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [mwsp_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // command_vx, command_vy, command_yaw, delta_front_left, delta_front_right,
    // delta_rear_left, delta_rear_right, elapsed_us, zero fill
    input  logic [135:0]                  s_axis_tdata,
    // command_stale
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // drive_front_left, drive_front_right, drive_rear_left, drive_rear_right,
    // speed_front_left, speed_front_right, speed_rear_left, speed_rear_right, zero fill
    output logic [103:0]                  m_axis_tdata
);
    import mwsp_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_WK    = 12'b000000000010,
        S_TGT   = 12'b000000000100,
        S_SMUL  = 12'b000000001000,
        S_SDIV  = 12'b000000010000,
        S_SWAIT = 12'b000000100000,
        S_PI0   = 12'b000001000000,
        S_PI1   = 12'b000010000000,
        S_PI2   = 12'b000100000000,
        S_PI3   = 12'b001000000000,
        S_PI4   = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] gains_reg [4];
    logic [15:0] geometry_reg, scale_reg, step_reg;
    logic [3:0]  signs_reg;

    logic signed [15:0] vx_reg, vy_reg, yaw_reg;
    logic signed [15:0] delta_reg [4];
    logic [19:0]        elapsed_reg;
    logic signed [15:0] tgt_reg [4];
    logic signed [15:0] spd_reg [4];
    logic [8:0]         drive_reg [4];
    logic signed [31:0] integ_reg [4];
    logic signed [16:0] err_reg;
    logic signed [31:0] itmp_reg;
    logic signed [39:0] kiint_reg;
    logic [1:0]         w_reg;
    logic               m_valid_reg;
    logic [103:0]       m_data_reg;

    logic signed [MULA_W-1:0] mul_a;
    logic signed [MULB_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     div_start;
    logic [DIVN_W-1:0]        div_num;
    logic [DIVD_W-1:0]        div_den;
    div_stat_t                div_stat;
    logic [DIVN_W-1:0]        quo;

    logic [15:0]        kp, ki;
    logic [7:0]         base;
    logic signed [HEAD_W:0] head;
    logic [HEAD_W-1:0]  head_pos;
    logic signed [15:0] d_w, tgt_w, spd_w;
    logic [16:0]        d_abs;
    logic               spd_neg;
    logic signed [16:0] err_now;
    logic signed [63:0] wk;
    logic signed [63:0] isum;
    logic signed [31:0] integ_clamped;
    logic [31:0]        limit;
    logic signed [39:0] pi_out;
    logic [39:0]        out_abs;
    logic [24:0]        pwm_mag;
    logic [HEAD_W-1:0]  pwm_sat;
    logic [8:0]         drive_now;
    logic [63:0]        spd_dividend;
    logic signed [15:0] spd_now;

    mwsp_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    mwsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .stat     (div_stat),
        .quotient (quo)
    );

    always_comb
    begin
        kp       = gains_reg[w_reg][15:0];
        ki       = gains_reg[w_reg][31:16];
        base     = gains_reg[w_reg][39:32];
        head     = (HEAD_W + 1)'(PWM_MAX) - (HEAD_W + 1)'(base);
        head_pos = head[HEAD_W] ? '0 : head[HEAD_W-1:0];
        d_w      = delta_reg[w_reg];
        tgt_w    = tgt_reg[w_reg];
        spd_w    = spd_reg[w_reg];
        d_abs    = d_w[15] ? (17'd0 - 17'(d_w)) : 17'(d_w);
        spd_neg  = d_w[15] ^ signs_reg[w_reg];
        err_now  = 17'(tgt_w) - 17'(spd_w);
        wk       = shr_round(64'(prod), 12);

        spd_dividend = {28'd0, prod[31:0], 4'd0} + 64'(elapsed_reg >> 1);
        if (!spd_neg)
            spd_now = (quo > DIVN_W'(32767)) ? 16'sh7fff : quo[15:0];
        else
            spd_now = (quo > DIVN_W'(32768)) ? 16'sh8000 : 16'(DIVN_W'(0) - quo);

        isum = 64'(integ_reg[w_reg]) + shr_round(64'(prod), 4);
        limit = (quo > DIVN_W'(32'h7fffffff)) ? 32'h7fffffff : quo[31:0];
        if (ki == 16'd0)
            integ_clamped = itmp_reg;
        else if (itmp_reg > signed'(limit))
            integ_clamped = signed'(limit);
        else if (itmp_reg < -signed'(limit))
            integ_clamped = -signed'(limit);
        else
            integ_clamped = itmp_reg;

        pi_out  = prod[39:0] + kiint_reg;
        out_abs = pi_out[39] ? (40'd0 - 40'(pi_out)) : 40'(pi_out);
        pwm_mag = 25'(base) + 25'(out_abs[39:16]);
        pwm_sat = (pwm_mag > 25'(PWM_MAX)) ? HEAD_W'(PWM_MAX) : pwm_mag[HEAD_W-1:0];
        if (!tgt_w[15] && tgt_w != 16'sd0 && !pi_out[39] && pi_out != 40'sd0)
            drive_now = pwm_sat[8:0];
        else if (tgt_w[15] && pi_out[39])
            drive_now = 9'(HEAD_W'(0) - pwm_sat);
        else
            drive_now = '0;

        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = spd_dividend[DIVN_W-1:0];
        div_den   = elapsed_reg;
        unique case (state_reg)
            S_WK:
            begin
                mul_a = MULA_W'(yaw_reg);
                mul_b = MULB_W'({2'b00, geometry_reg});
            end
            S_SMUL:
            begin
                mul_a = MULA_W'({1'b0, d_abs});
                mul_b = MULB_W'({2'b00, scale_reg});
            end
            S_SDIV:
                div_start = 1'b1;
            S_PI0:
            begin
                mul_a     = MULA_W'(err_now);
                mul_b     = MULB_W'({2'b00, step_reg});
                div_start = (tgt_w != 16'sd0);
                div_num   = DIVN_W'({head_pos, 28'd0});
                div_den   = DIVD_W'(ki);
            end
            S_PI2:
            begin
                mul_a = MULA_W'(integ_clamped);
                mul_b = MULB_W'({2'b00, ki});
            end
            S_PI3:
            begin
                mul_a = MULA_W'(err_reg);
                mul_b = MULB_W'({2'b00, kp});
            end
            default:
            begin
                mul_a = '0;
            end
        endcase

        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_axis_tvalid) state_next = S_WK;
            S_WK:    state_next = S_TGT;
            S_TGT:   state_next = S_SMUL;
            S_SMUL:  state_next = S_SDIV;
            S_SDIV:  state_next = S_SWAIT;
            S_SWAIT:
                if (div_stat.done)
                    state_next = (w_reg == 2'd3) ? S_PI0 : S_SMUL;
            S_PI0:
                if (tgt_w == 16'sd0)
                    state_next = (w_reg == 2'd3) ? S_DONE : S_PI0;
                else
                    state_next = S_PI1;
            S_PI1:   state_next = S_PI2;
            S_PI2:   if (div_stat.done) state_next = S_PI3;
            S_PI3:   state_next = S_PI4;
            S_PI4:   state_next = (w_reg == 2'd3) ? S_DONE : S_PI0;
            S_DONE:  if (!m_valid_reg || m_axis_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            w_reg        <= '0;
            m_valid_reg  <= 1'b0;
            geometry_reg <= GEOMETRY_RESET;
            scale_reg    <= SCALE_RESET;
            step_reg     <= STEP_RESET;
            signs_reg    <= SIGNS_RESET;
            for (int i = 0; i < 4; i++)
            begin
                gains_reg[i] <= '0;
                integ_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GAINS_FL: gains_reg[0] <= cfg_data;
                    CFG_GAINS_FR: gains_reg[1] <= cfg_data;
                    CFG_GAINS_RL: gains_reg[2] <= cfg_data;
                    CFG_GAINS_RR: gains_reg[3] <= cfg_data;
                    CFG_GEOMETRY: geometry_reg <= cfg_data[15:0];
                    CFG_SCALE:    scale_reg    <= cfg_data[15:0];
                    CFG_STEP:     step_reg     <= cfg_data[15:0];
                    CFG_SIGNS:    signs_reg    <= cfg_data[3:0];
                    default:      signs_reg    <= signs_reg;
                endcase
            end
            if (state_reg == S_SWAIT && div_stat.done)
                w_reg <= w_reg + 2'd1;
            if (state_reg == S_PI4 || (state_reg == S_PI0 && tgt_w == 16'sd0))
                w_reg <= w_reg + 2'd1;
            if (state_reg == S_PI0 && tgt_w == 16'sd0)
                integ_reg[w_reg] <= '0;
            if (state_reg == S_PI2 && div_stat.done)
                integ_reg[w_reg] <= integ_clamped;
            if (state_reg == S_DONE && (!m_valid_reg || m_axis_tready))
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            vx_reg  <= s_axis_tuser ? 16'sd0 : s_axis_tdata[15:0];
            vy_reg  <= s_axis_tuser ? 16'sd0 : s_axis_tdata[31:16];
            yaw_reg <= s_axis_tuser ? 16'sd0 : s_axis_tdata[47:32];
            for (int i = 0; i < 4; i++)
                delta_reg[i] <= s_axis_tdata[48 + 16*i +: 16];
            elapsed_reg <= (s_axis_tdata[131:112] == 20'd0) ? 20'd1 : s_axis_tdata[131:112];
        end
        if (state_reg == S_TGT)
        begin
            tgt_reg[0] <= sat16(64'(vx_reg) + 64'(vy_reg) - wk);
            tgt_reg[1] <= sat16(64'(vx_reg) - 64'(vy_reg) + wk);
            tgt_reg[2] <= sat16(64'(vx_reg) - 64'(vy_reg) - wk);
            tgt_reg[3] <= sat16(64'(vx_reg) + 64'(vy_reg) + wk);
        end
        if (state_reg == S_SWAIT && div_stat.done)
            spd_reg[w_reg] <= spd_now;
        if (state_reg == S_PI0)
        begin
            err_reg <= err_now;
            if (tgt_w == 16'sd0)
                drive_reg[w_reg] <= '0;
        end
        if (state_reg == S_PI1)
        begin
            if (isum > 64'sd2147483647)
                itmp_reg <= 32'sh7fffffff;
            else if (isum < -64'sd2147483648)
                itmp_reg <= 32'sh80000000;
            else
                itmp_reg <= isum[31:0];
        end
        if (state_reg == S_PI3)
            kiint_reg <= 40'(shr_round(64'(prod), 12));
        if (state_reg == S_PI4)
            drive_reg[w_reg] <= drive_now;
        if (state_reg == S_DONE && (!m_valid_reg || m_axis_tready))
            m_data_reg <= {4'd0, spd_reg[3], spd_reg[2], spd_reg[1], spd_reg[0],
                           drive_reg[3], drive_reg[2], drive_reg[1], drive_reg[0]};
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    `ASSERT_IMPL(a_ready_div_idle, s_axis_tready, !div_stat.busy, "divider busy while ready")
    `ASSERT_IMPL(a_done_in_wait, div_stat.done,
        (state_reg == S_SWAIT) || (state_reg == S_PI2), "divider result outside a wait")
    `ASSERT_CLK(a_accept_blocks, !(s_axis_tvalid && s_axis_tready)
        || (state_next == S_WK), "accepted transfer did not start a tick")
endmodule
